// ===== rtl/rsfp_pkg.sv =====
// ----------------------------------------------------------------------------
// rsfp_pkg: shared types and constants of the range sensor frame parser
// Event codes, field widths, register indexes and reset values.
// ----------------------------------------------------------------------------
package rsfp_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 7;
  localparam int unsigned POS_W           = 4;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 16;

  localparam logic [7:0]  HDR_FIRST  = 8'hAA;
  localparam logic [7:0]  HDR_SECOND = 8'hFF;
  localparam logic [15:0] QUAL_KNEE  = 16'hFF00;
  localparam logic [7:0]  QUAL_MAX   = 8'hFF;
  localparam logic [15:0] AGE_MAX    = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd2;

  localparam logic [15:0] MIN_DIST_RST = 16'd20;
  localparam logic [15:0] MAX_DIST_RST = 16'd18000;
  localparam logic [15:0] TIMEOUT_RST  = 16'd100;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_GOOD    = 3'd1,
    EV_CSUM    = 3'd2,
    EV_RANGE   = 3'd3,
    EV_TIMEOUT = 3'd4
  } event_e;

  typedef struct packed {
    logic [15:0] min_distance_mm;
    logic [15:0] max_distance_mm;
    logic [15:0] timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] distance_mm;
    logic [7:0]  quality;
    logic        sample_valid;
    logic [15:0] age_ms;
    logic [31:0] good_frames;
    logic [31:0] checksum_errors;
    logic [31:0] range_errors;
  } result_t;

endpackage

// ===== rtl/rsfp_if.sv =====
// ----------------------------------------------------------------------------
// rsfp_if: stream channels of the range sensor frame parser
// Input channel (byte or tick) and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rsfp_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface rsfp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [15:0] distance_mm;
  logic [7:0]  quality;
  logic        sample_valid;
  logic [15:0] age_ms;
  logic [31:0] good_frames;
  logic [31:0] checksum_errors;
  logic [31:0] range_errors;

  modport source (output valid, output event_res, output distance_mm, output quality,
                  output sample_valid, output age_ms, output good_frames,
                  output checksum_errors, output range_errors, input ready);
  modport sink   (input valid, input event_res, input distance_mm, input quality,
                  input sample_valid, input age_ms, input good_frames,
                  input checksum_errors, input range_errors, output ready);
endinterface

// ===== rtl/range_sensor_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// range_sensor_frame_parser_top: serial range sensor frame parser
// The accepted beat goes into the input register, then through the
// parse/update logic into the result register; a result still held on
// the output stalls the beat in the input register.
// Throughput: one beat per cycle while the result channel takes each result.
// Reset: asynchronous active low; clears parser, sample, counters and
// loads register defaults 20 / 18000 / 100. Frame byte store is not reset.
// ----------------------------------------------------------------------------
module range_sensor_frame_parser_top #(
  parameter int unsigned FRAME_BYTES = rsfp_pkg::FRAME_BYTES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rsfp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rsfp_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  rsfp_in_if.sink                            in_i,
  rsfp_out_if.source                         out_o
);

  rsfp_pkg::cfg_t    cfg_q;
  rsfp_pkg::result_t res, res_q;
  logic              s1_valid_q, s1_mode_q;
  logic [7:0]        s1_byte_q;
  logic              out_valid_q;
  logic              adv, in_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_distance_mm <= rsfp_pkg::MIN_DIST_RST;
      cfg_q.max_distance_mm <= rsfp_pkg::MAX_DIST_RST;
      cfg_q.timeout_ms      <= rsfp_pkg::TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rsfp_pkg::REG_MIN_DIST: cfg_q.min_distance_mm <= cfg_wdata_i;
        rsfp_pkg::REG_MAX_DIST: cfg_q.max_distance_mm <= cfg_wdata_i;
        rsfp_pkg::REG_TIMEOUT:  cfg_q.timeout_ms      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // beat advances from the input register when the result slot frees up
  assign adv        = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || adv;
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= in_acc || (s1_valid_q && !adv);
      out_valid_q <= adv || (out_valid_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_mode_q <= in_i.mode;
      s1_byte_q <= in_i.rx_byte;
    end
    if (adv) begin
      res_q <= res;
    end
  end

  rsfp_core #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (adv),
    .mode_i    (s1_mode_q),
    .rx_byte_i (s1_byte_q),
    .cfg_i     (cfg_q),
    .res_o     (res)
  );

  assign out_o.valid           = out_valid_q;
  assign out_o.event_res       = res_q.event_res;
  assign out_o.distance_mm     = res_q.distance_mm;
  assign out_o.quality         = res_q.quality;
  assign out_o.sample_valid    = res_q.sample_valid;
  assign out_o.age_ms          = res_q.age_ms;
  assign out_o.good_frames     = res_q.good_frames;
  assign out_o.checksum_errors = res_q.checksum_errors;
  assign out_o.range_errors    = res_q.range_errors;

endmodule

// ===== rtl/rsfp_core.sv =====
// ----------------------------------------------------------------------------
// rsfp_core: frame sync, checksum, range check and sample aging
// Updates the parser and sample state for one beat per step and presents
// the state after that beat as a result word.
// ----------------------------------------------------------------------------
module rsfp_core #(
  parameter int unsigned FRAME_BYTES = rsfp_pkg::FRAME_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             mode_i,
  input  logic [7:0]       rx_byte_i,
  input  rsfp_pkg::cfg_t   cfg_i,
  output rsfp_pkg::result_t res_o
);

  localparam logic [1:0] PH_HDR1 = 2'd0;
  localparam logic [1:0] PH_HDR2 = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  localparam int unsigned PW = rsfp_pkg::POS_W;
  localparam logic [PW-1:0] POS_FIRST = PW'(2);
  localparam logic [PW-1:0] POS_LAST  = PW'(FRAME_BYTES);

  logic [1:0]    phase_q, phase_d;
  logic [PW-1:0] pos_q, pos_d, pos_inc;
  logic [7:0]    store_q [2:6];
  logic [7:0]    store_d [2:6];
  logic [7:0]    view    [2:6];
  logic [15:0]   dist_q, dist_d;
  logic [7:0]    qual_q, qual_d;
  logic          valid_q, valid_d;
  logic [15:0]   age_q, age_d;
  logic [31:0]   elapsed_q, elapsed_d, elapsed_inc;
  logic [31:0]   good_q, good_d;
  logic [31:0]   csum_q, csum_d;
  logic [31:0]   range_q, range_d;
  logic [7:0]    sum;
  logic [15:0]   dist_rx, strength_rx;
  logic          finish;
  rsfp_pkg::event_e ev;

  always_comb begin
    pos_inc = pos_q + PW'(1);
    finish  = (phase_q == PH_DATA) && ((pos_inc >= POS_LAST) || (pos_inc == '0));
    // frame bytes as they stand after this beat is written
    for (int k = 2; k <= 6; k++) begin
      view[k] = (phase_q == PH_DATA && pos_q == PW'(k)) ? rx_byte_i : store_q[k];
    end
    sum         = view[2] + view[3] + view[4] + view[5];
    dist_rx     = {view[2], view[3]};
    strength_rx = {view[4], view[5]};
    elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 32'd1;
  end

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    store_d   = store_q;
    dist_d    = dist_q;
    qual_d    = qual_q;
    valid_d   = valid_q;
    age_d     = age_q;
    elapsed_d = elapsed_q;
    good_d    = good_q;
    csum_d    = csum_q;
    range_d   = range_q;
    ev        = rsfp_pkg::EV_NONE;
    if (mode_i) begin
      elapsed_d = elapsed_inc;
      if (valid_q && (elapsed_inc > {16'd0, cfg_i.timeout_ms})) begin
        valid_d = 1'b0;
        age_d   = (elapsed_inc > {16'd0, rsfp_pkg::AGE_MAX}) ? rsfp_pkg::AGE_MAX
                                                             : elapsed_inc[15:0];
        ev      = rsfp_pkg::EV_TIMEOUT;
      end
    end else begin
      unique case (phase_q)
        PH_HDR2: begin
          if (rx_byte_i == rsfp_pkg::HDR_SECOND) begin
            pos_d   = POS_FIRST;
            phase_d = PH_DATA;
          end else begin
            phase_d = PH_HDR1;
          end
        end
        PH_DATA: begin
          for (int k = 2; k <= 6; k++) begin
            store_d[k] = view[k];
          end
          pos_d = pos_inc;
          if (finish) begin
            phase_d = PH_HDR1;
            pos_d   = '0;
            if (sum != view[6]) begin
              csum_d = csum_q + 32'd1;
              ev     = rsfp_pkg::EV_CSUM;
            end else if (dist_rx < cfg_i.min_distance_mm ||
                         dist_rx > cfg_i.max_distance_mm) begin
              range_d = range_q + 32'd1;
              valid_d = 1'b0;
              ev      = rsfp_pkg::EV_RANGE;
            end else begin
              dist_d    = dist_rx;
              qual_d    = (strength_rx > rsfp_pkg::QUAL_KNEE) ? rsfp_pkg::QUAL_MAX
                                                              : strength_rx[15:8];
              age_d     = '0;
              valid_d   = 1'b1;
              elapsed_d = '0;
              good_d    = good_q + 32'd1;
              ev        = rsfp_pkg::EV_GOOD;
            end
          end
        end
        default: begin
          // header hunt, also taken by the unused phase code
          phase_d = (rx_byte_i == rsfp_pkg::HDR_FIRST) ? PH_HDR2 : PH_HDR1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR1;
      pos_q     <= '0;
      dist_q    <= '0;
      qual_q    <= '0;
      valid_q   <= 1'b0;
      age_q     <= '0;
      elapsed_q <= '0;
      good_q    <= '0;
      csum_q    <= '0;
      range_q   <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      dist_q    <= dist_d;
      qual_q    <= qual_d;
      valid_q   <= valid_d;
      age_q     <= age_d;
      elapsed_q <= elapsed_d;
      good_q    <= good_d;
      csum_q    <= csum_d;
      range_q   <= range_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      store_q <= store_d;
    end
  end

  assign res_o.event_res       = ev;
  assign res_o.distance_mm     = dist_d;
  assign res_o.quality         = qual_d;
  assign res_o.sample_valid    = valid_d;
  assign res_o.age_ms          = age_d;
  assign res_o.good_frames     = good_d;
  assign res_o.checksum_errors = csum_d;
  assign res_o.range_errors    = range_d;

`ifndef SYNTHESIS
  a_data_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> (pos_q >= POS_FIRST && pos_q < POS_LAST))
    else $error("byte position outside frame body");

  a_good_clears_age: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && ev == rsfp_pkg::EV_GOOD |=> valid_q && elapsed_q == '0 && age_q == '0)
    else $error("good frame did not refresh sample");

  a_timeout_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && ev == rsfp_pkg::EV_TIMEOUT |=> !valid_q && phase_q == $past(phase_q))
    else $error("timeout left sample valid or moved parser");

  a_tick_no_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && mode_i |=> $stable(good_q) && $stable(csum_q) && $stable(range_q))
    else $error("tick changed frame counters");
`endif

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: range sensor frame parser
// Drives serial bytes and millisecond ticks into the parser, tracks the
// expected sample state and counters in a software copy of the parser, and
// checks every result beat field by field. Runs directed frames first, then
// random well-formed and broken frames, noise and tick bursts under several
// register settings and idle patterns.
// ----------------------------------------------------------------------------
typedef enum logic [1:0] {
  PH_FIRST  = 2'd0,
  PH_SECOND = 2'd1,
  PH_BODY   = 2'd2
} parse_phase_e;

class sensor_tracker;
  logic [15:0]                min_dist = rsfp_pkg::MIN_DIST_RST;
  logic [15:0]                max_dist = rsfp_pkg::MAX_DIST_RST;
  logic [15:0]                tmo      = rsfp_pkg::TIMEOUT_RST;
  parse_phase_e               phase    = PH_FIRST;
  logic [rsfp_pkg::POS_W-1:0] pos      = '0;
  logic [7:0]                 frame [16];
  logic [15:0]                dist_q    = '0;
  logic [7:0]                 qual_q    = '0;
  logic                       valid_q   = 1'b0;
  logic [15:0]                age_q     = '0;
  logic [31:0]                elapsed   = '0;
  logic [31:0]                good_cnt  = '0;
  logic [31:0]                csum_cnt  = '0;
  logic [31:0]                range_cnt = '0;
  rsfp_pkg::result_t          readings_due [$];
  int                         mismatches = 0;
  int                         checked    = 0;

  function void set_reg(logic [rsfp_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    case (idx)
      rsfp_pkg::REG_MIN_DIST: min_dist = val;
      rsfp_pkg::REG_MAX_DIST: max_dist = val;
      rsfp_pkg::REG_TIMEOUT:  tmo      = val;
      default: ;
    endcase
  endfunction

  function int pending();
    return readings_due.size();
  endfunction

  // one beat in, one expected reading out
  function void take_item(logic tick, logic [7:0] b);
    rsfp_pkg::event_e  ev;
    logic [7:0]        sum;
    logic [15:0]       rx_dist;
    logic [15:0]       strength;
    rsfp_pkg::result_t r;
    ev = rsfp_pkg::EV_NONE;
    if (tick) begin
      if (elapsed != 32'hFFFF_FFFF) elapsed = elapsed + 32'd1;
      if (valid_q && elapsed > {16'h0000, tmo}) begin
        valid_q = 1'b0;
        age_q   = (elapsed > 32'h0000_FFFF) ? rsfp_pkg::AGE_MAX : elapsed[15:0];
        ev      = rsfp_pkg::EV_TIMEOUT;
      end
    end else begin
      case (phase)
        PH_SECOND: begin
          if (b == rsfp_pkg::HDR_SECOND) begin
            frame[1] = b;
            pos      = 4'd2;
            phase    = PH_BODY;
          end else begin
            // mismatching byte is dropped, not taken as a new header
            phase = PH_FIRST;
          end
        end
        PH_BODY: begin
          frame[pos] = b;
          pos = pos + 1'b1;
          if (pos >= rsfp_pkg::FRAME_BYTES_DEF || pos == '0) begin
            sum      = frame[2] + frame[3] + frame[4] + frame[5];
            rx_dist  = {frame[2], frame[3]};
            strength = {frame[4], frame[5]};
            if (sum != frame[6]) begin
              csum_cnt = csum_cnt + 32'd1;
              ev       = rsfp_pkg::EV_CSUM;
            end else if (rx_dist < min_dist || rx_dist > max_dist) begin
              range_cnt = range_cnt + 32'd1;
              valid_q   = 1'b0;
              ev        = rsfp_pkg::EV_RANGE;
            end else begin
              dist_q   = rx_dist;
              qual_q   = (strength > rsfp_pkg::QUAL_KNEE) ? rsfp_pkg::QUAL_MAX
                                                          : strength[15:8];
              age_q    = '0;
              valid_q  = 1'b1;
              elapsed  = '0;
              good_cnt = good_cnt + 32'd1;
              ev       = rsfp_pkg::EV_GOOD;
            end
            phase = PH_FIRST;
            pos   = '0;
          end
        end
        default: begin
          phase = PH_FIRST;
          if (b == rsfp_pkg::HDR_FIRST) begin
            frame[0] = b;
            phase    = PH_SECOND;
          end
        end
      endcase
    end
    r = '{event_res: ev, distance_mm: dist_q, quality: qual_q, sample_valid: valid_q,
          age_ms: age_q, good_frames: good_cnt, checksum_errors: csum_cnt,
          range_errors: range_cnt};
    readings_due.push_back(r);
  endfunction

  task report(string msg);
    $display("MISMATCH result %0d: %s", checked, msg);
    mismatches++;
  endtask

  task check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task check_reading(rsfp_pkg::result_t got);
    rsfp_pkg::result_t want;
    checked++;
    if (readings_due.size() == 0) begin
      report("result beat with nothing expected");
    end else begin
      want = readings_due.pop_front();
      check_field("event_res", got.event_res, want.event_res);
      check_field("distance_mm", got.distance_mm, want.distance_mm);
      check_field("quality", got.quality, want.quality);
      check_field("sample_valid", got.sample_valid, want.sample_valid);
      check_field("age_ms", got.age_ms, want.age_ms);
      check_field("good_frames", got.good_frames, want.good_frames);
      check_field("checksum_errors", got.checksum_errors, want.checksum_errors);
      check_field("range_errors", got.range_errors, want.range_errors);
    end
  endtask
endclass

module testbench;

  localparam int LATENCY     = 2;
  localparam int CYCLE_LIMIT = 100000;
  localparam logic [rsfp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [rsfp_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [rsfp_pkg::CFG_DATA_W-1:0] cfg_wdata;

  rsfp_in_if  in_ch ();
  rsfp_out_if out_ch ();

  sensor_tracker     sb;
  rsfp_pkg::result_t seen;
  int                sent;
  int                cycles;
  int                send_idle_pct;
  int                recv_idle_pct;

  range_sensor_frame_parser_top u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: check the beat taken at this edge, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen = '{event_res: out_ch.event_res, distance_mm: out_ch.distance_mm,
               quality: out_ch.quality, sample_valid: out_ch.sample_valid,
               age_ms: out_ch.age_ms, good_frames: out_ch.good_frames,
               checksum_errors: out_ch.checksum_errors,
               range_errors: out_ch.range_errors};
      sb.check_reading(seen);
    end
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task send_item(input logic tick, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= tick;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.take_item(tick, b);
    sent++;
  endtask

  task send_ticks(input int n);
    repeat (n) send_item(1'b1, 8'($urandom));
  endtask

  // csum_flip of zero gives a correct checksum
  task send_frame(input logic [15:0] frame_dist, input logic [15:0] strength,
                  input logic [7:0] csum_flip);
    logic [7:0] cs;
    cs = frame_dist[15:8] + frame_dist[7:0] + strength[15:8] + strength[7:0];
    send_item(1'b0, rsfp_pkg::HDR_FIRST);
    send_item(1'b0, rsfp_pkg::HDR_SECOND);
    send_item(1'b0, frame_dist[15:8]);
    send_item(1'b0, frame_dist[7:0]);
    send_item(1'b0, strength[15:8]);
    send_item(1'b0, strength[7:0]);
    send_item(1'b0, cs ^ csum_flip);
  endtask

  task wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task write_reg(input logic [rsfp_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task apply_settings(input logic [15:0] lo, input logic [15:0] hi,
                      input logic [15:0] limit, input bit poke_unused);
    wait_idle();
    write_reg(rsfp_pkg::REG_MIN_DIST, lo);
    write_reg(rsfp_pkg::REG_MAX_DIST, hi);
    write_reg(rsfp_pkg::REG_TIMEOUT, limit);
    if (poke_unused) write_reg(REG_UNUSED, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  task run_random(input int count);
    int          goal;
    int          kind;
    int          n;
    logic [15:0] d;
    logic [15:0] s;
    goal = sent + count;
    while (sent < goal) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        case ($urandom_range(7))
          0: d = sb.min_dist;
          1: d = sb.max_dist;
          2: d = sb.min_dist - 16'd1;
          3: d = sb.max_dist + 16'd1;
          4: d = 16'h0000;
          5: d = 16'hFFFF;
          default: begin
            if (sb.min_dist <= sb.max_dist) d = 16'($urandom_range(sb.max_dist, sb.min_dist));
            else d = 16'($urandom);
          end
        endcase
        case ($urandom_range(5))
          0: s = 16'hFF00;
          1: s = 16'hFF01;
          2: s = 16'hFFFF;
          3: s = 16'h0000;
          default: s = 16'($urandom);
        endcase
        send_frame(d, s, ($urandom_range(99) < 15) ? 8'($urandom_range(255, 1)) : 8'h00);
      end else if (kind < 75) begin
        // now and then a burst long enough to run out the sample
        if ($urandom_range(9) == 0 && sb.tmo < 16'd200) n = int'(sb.tmo) + 2;
        else n = $urandom_range(8, 1);
        send_ticks(n);
      end else if (kind < 85) begin
        send_item(1'b0, 8'($urandom));
      end else if (kind < 92) begin
        send_item(1'b0, rsfp_pkg::HDR_FIRST);
        send_item(1'b0, ($urandom_range(1) != 0) ? rsfp_pkg::HDR_FIRST
                                                 : 8'($urandom_range(254)));
      end else begin
        // cut-short frame: the following beats fill it up
        send_item(1'b0, rsfp_pkg::HDR_FIRST);
        send_item(1'b0, rsfp_pkg::HDR_SECOND);
        n = $urandom_range(4, 1);
        repeat (n) send_item(1'b0, 8'($urandom));
      end
    end
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.mode    = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    sent          = 0;
    cycles        = 0;
    send_idle_pct = 8;
    recv_idle_pct = 53;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: low limit with strength above the knee, distance past the
    // high limit, broken header, bad checksum at the high limit, one tick
    send_frame(rsfp_pkg::MIN_DIST_RST, 16'hFF01, 8'h00);
    send_frame(rsfp_pkg::MAX_DIST_RST + 16'd1, 16'h1234, 8'h00);
    send_item(1'b0, rsfp_pkg::HDR_FIRST);
    send_item(1'b0, rsfp_pkg::HDR_FIRST);
    send_frame(rsfp_pkg::MAX_DIST_RST, 16'hFF00, 8'h01);
    send_item(1'b1, 8'hFF);

    apply_settings(rsfp_pkg::MIN_DIST_RST, rsfp_pkg::MAX_DIST_RST,
                   rsfp_pkg::TIMEOUT_RST, 1'b0);
    run_random(290);
    apply_settings(16'h0000, 16'hFFFF, 16'h0000, 1'b0);
    run_random(290);

    send_idle_pct = 53;
    recv_idle_pct = 8;
    // crossed limits: nothing is in range
    apply_settings(16'd1000, 16'd500, 16'd5, 1'b0);
    run_random(290);
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    run_random(290);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // lowered timeout applies at the next tick
    apply_settings(16'd300, 16'd3000, 16'd100, 1'b0);
    send_frame(16'd1000, 16'h4567, 8'h00);
    send_ticks(50);
    wait_idle();
    write_reg(rsfp_pkg::REG_TIMEOUT, 16'd10);
    cfg_we <= 1'b0;
    send_ticks(1);
    run_random(290);

    // wide limits, timeout that does not run out here
    apply_settings(16'd5, 16'd40000, 16'hFFFF, 1'b0);
    send_frame(16'd500, 16'h00FF, 8'h00);
    run_random(210);

    wait_idle();
    if (sb.mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
